>>> rtl/fsk4_pkg.sv
// Shared types, constants and helper functions of the 4FSK slicer and sync detector.
package fsk4_pkg;

	// Sizes
	localparam int HISTORY_DEPTH_DEF = 192;
	localparam int WINDOW_LEN        = 8;
	localparam int PATTERN_COUNT     = 4;
	localparam int PATTERN_W         = 2 * WINDOW_LEN;
	localparam int SAMPLE_W          = 16;
	localparam int CFG_INDEX_W       = 3;
	localparam int CFG_DATA_W        = 16;
	localparam int IN_TDATA_W        = 16;
	localparam int OUT_TDATA_W       = 48;

	// Clip limit of the stored samples and scale of the level percent
	localparam logic signed [SAMPLE_W-1:0] CLIP_LIMIT = 16'sd32760;
	localparam logic [14:0]                CLIP_MAG   = 15'd32760;
	localparam logic [6:0]                 PCT_SCALE  = 7'd100;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_INVERT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LSF    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STREAM = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PACKET = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BERT   = 3'd4;

	// Reset values of the sync words
	localparam logic [PATTERN_W-1:0] LSF_RESET    = 16'd22007;
	localparam logic [PATTERN_W-1:0] STREAM_RESET = 16'd65373;
	localparam logic [PATTERN_W-1:0] PACKET_RESET = 16'd30207;
	localparam logic [PATTERN_W-1:0] BERT_RESET   = 16'd57173;

	// Sync type codes
	localparam logic [2:0] SYNC_NONE   = 3'd0;
	localparam logic [2:0] SYNC_LSF    = 3'd1;
	localparam logic [2:0] SYNC_STREAM = 3'd2;
	localparam logic [2:0] SYNC_PACKET = 3'd3;
	localparam logic [2:0] SYNC_BERT   = 3'd4;

	// Symbol levels
	localparam logic signed [2:0] LVL_ZERO = 3'sd0;
	localparam logic signed [2:0] LVL_P1   = 3'sd1;
	localparam logic signed [2:0] LVL_P3   = 3'sd3;
	localparam logic signed [2:0] LVL_N1   = -3'sd1;
	localparam logic signed [2:0] LVL_N3   = -3'sd3;

	// Dibit codes
	localparam logic [1:0] DIBIT_P1 = 2'd0;
	localparam logic [1:0] DIBIT_P3 = 2'd1;
	localparam logic [1:0] DIBIT_N1 = 2'd2;
	localparam logic [1:0] DIBIT_N3 = 2'd3;

	// Control state of the top level
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} fsm_state_t;

	// Commands to the history unit
	typedef struct packed {
		logic start;
		logic clear;
		logic store;
	} hist_ctrl_t;

	// Status of the history unit
	typedef struct packed {
		logic                       done;
		logic [14:0]                max;
		logic signed [SAMPLE_W-1:0] min;
	} hist_stat_t;

	// Commands to the sync window
	typedef struct packed {
		logic shift;
		logic clear;
	} sync_ctrl_t;

	// Map a symbol level to its dibit; level zero maps like +1
	function automatic logic [1:0] level_to_dibit(input logic signed [2:0] level);
		logic [1:0] d;
		case (level)
			LVL_P3:  d = DIBIT_P3;
			LVL_N1:  d = DIBIT_N1;
			LVL_N3:  d = DIBIT_N3;
			default: d = DIBIT_P1;
		endcase
		return d;
	endfunction

	// Map a dibit of a sync word to its nominal level
	function automatic logic signed [2:0] dibit_to_level(input logic [1:0] dibit);
		logic signed [2:0] l;
		case (dibit)
			DIBIT_P3: l = LVL_P3;
			DIBIT_N1: l = LVL_N1;
			DIBIT_N3: l = LVL_N3;
			default:  l = LVL_P1;
		endcase
		return l;
	endfunction

endpackage

>>> rtl/fsk4_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module fsk4_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/fsk4_hist.sv
// Sample history memory with fill count and clipped extrema scan.
module fsk4_hist #(
	parameter int DEPTH = fsk4_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fsk4_pkg::hist_ctrl_t                 ctrl,
	input  logic signed [fsk4_pkg::SAMPLE_W-1:0] sample,
	output fsk4_pkg::hist_stat_t                 stat
);
	import fsk4_pkg::*;

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [AW-1:0]              ptr_q;
	logic [CNT_W-1:0]           fill_q;
	logic [CNT_W-1:0]           rd_cnt_q;
	logic                       scanning_q;
	logic                       rvalid_s1;
	logic signed [SAMPLE_W-1:0] mx_q;
	logic signed [SAMPLE_W-1:0] mn_q;
	logic [SAMPLE_W-1:0]        rdata;
	logic signed [SAMPLE_W-1:0] clip_v;
	logic                       rd_issue;

	// Entries at or beyond the fill count hold nothing stored since the last clear and need no read
	assign rd_issue = scanning_q && (rd_cnt_q != fill_q);

	fsk4_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctrl.store),
		.waddr(ptr_q),
		.wdata(sample),
		.re   (rd_issue),
		.raddr(rd_cnt_q[AW-1:0]),
		.rdata(rdata)
	);

	// Clip the read sample to the symmetric limit
	always_comb begin
		clip_v = $signed(rdata);
		if (clip_v > CLIP_LIMIT) begin
			clip_v = CLIP_LIMIT;
		end else if (clip_v < -CLIP_LIMIT) begin
			clip_v = -CLIP_LIMIT;
		end
	end

	// Advance write pointer, fill count and read sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			fill_q     <= '0;
			rd_cnt_q   <= '0;
			scanning_q <= 1'b0;
			rvalid_s1  <= 1'b0;
		end else begin
			rvalid_s1 <= rd_issue;
			if (ctrl.start) begin
				rd_cnt_q   <= '0;
				scanning_q <= 1'b1;
			end else if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end else if (stat.done) begin
				scanning_q <= 1'b0;
			end
			if (ctrl.clear) begin
				ptr_q  <= '0;
				fill_q <= '0;
			end else if (ctrl.store) begin
				if (ptr_q == AW'(DEPTH - 1)) begin
					ptr_q <= '0;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
				if (fill_q != CNT_W'(DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	// Accumulate maximum and minimum, both anchored at zero
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			mx_q <= '0;
			mn_q <= '0;
		end else if (rvalid_s1) begin
			if (clip_v > mx_q) begin
				mx_q <= clip_v;
			end
			if (clip_v < mn_q) begin
				mn_q <= clip_v;
			end
		end
	end

	assign stat.done = scanning_q && !rd_issue && !rvalid_s1;
	assign stat.max  = mx_q[14:0];
	assign stat.min  = mn_q;

endmodule

>>> rtl/fsk4_sync.sv
// Symbol window shift register and squared-distance sync word matcher.
module fsk4_sync (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  fsk4_pkg::sync_ctrl_t                                   ctrl,
	input  logic signed [2:0]                                      level,
	input  logic [fsk4_pkg::PATTERN_COUNT-1:0][fsk4_pkg::PATTERN_W-1:0] patterns,
	output logic [2:0]                                             sync_type
);
	import fsk4_pkg::*;

	// Element 0 holds the oldest symbol
	logic [WINDOW_LEN-1:0][2:0] win_q;
	logic [PATTERN_COUNT-1:0]   hit;

	// Sum of squared distances between the window and one sync word
	function automatic logic [8:0] pattern_cost(input logic [WINDOW_LEN-1:0][2:0] win,
			input logic [PATTERN_W-1:0] pat);
		logic signed [7:0] d;
		logic [7:0]        sq;
		logic [8:0]        acc;
		acc = '0;
		for (int k = 0; k < WINDOW_LEN; k++) begin
			d   = 8'($signed(win[k])) -
				8'(dibit_to_level(pat[2*(WINDOW_LEN-1-k) +: 2]));
			sq  = 8'(d * d);
			acc = acc + 9'(sq);
		end
		return acc;
	endfunction

	// Shift in the newest level, or clear to zero levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctrl.clear) begin
			win_q <= '0;
		end else if (ctrl.shift) begin
			for (int k = 0; k < WINDOW_LEN - 1; k++) begin
				win_q[k] <= win_q[k+1];
			end
			win_q[WINDOW_LEN-1] <= level;
		end
	end

	// Match each sync word
	always_comb begin
		for (int p = 0; p < PATTERN_COUNT; p++) begin
			hit[p] = pattern_cost(win_q, patterns[p]) < 9'd4;
		end
	end

	// Pick the first matching word in priority order
	always_comb begin
		if (hit[0]) begin
			sync_type = SYNC_LSF;
		end else if (hit[1]) begin
			sync_type = SYNC_STREAM;
		end else if (hit[2]) begin
			sync_type = SYNC_PACKET;
		end else if (hit[3]) begin
			sync_type = SYNC_BERT;
		end else begin
			sync_type = SYNC_NONE;
		end
	end

endmodule

>>> rtl/fsk4_slicer_sync_detector_unit.sv
// Top level of the 4FSK symbol slicer with frame sync detection.
// One sample per symbol enters on the s_ stream (sample in s_tdata, operation in s_tuser: 1 is
// carrier lost). A slice item scans the stored history through the single read port of the
// history RAM, one entry a cycle, reading only the F entries stored since the last clear or
// reset, where F is at most HISTORY_DEPTH. A carrier lost item answers with every field zero.
// The history needs no clearing pass: a fill count marks which entries have been written,
// and the rest are skipped and count as zero. The result beat waits in an output register,
// so a new item is accepted while it is still held; that item then waits in the done state
// until the held beat is taken.
module fsk4_slicer_sync_detector_unit #(
	parameter int HISTORY_DEPTH = fsk4_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [fsk4_pkg::IN_TDATA_W-1:0]    s_tdata,   // [15:0] sample
	input  logic                               s_tuser,   // [0] operation
	// Result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [2:0] symbol_level, [4:3] dibit, [7:5] sync_type, [8] in_sync,
	// [23:9] window_max, [39:24] window_min, [46:40] level_pct, [47] zero
	output logic [fsk4_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// Configuration write port
	input  logic                               cfg_we,
	input  logic [fsk4_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [fsk4_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import fsk4_pkg::*;

	fsm_state_t state_q, state_d;

	hist_ctrl_t hist_ctrl;
	hist_stat_t hist_stat;
	sync_ctrl_t sync_ctrl;

	logic                                    accept;
	logic                                    load_out;
	logic                                    op_q;
	logic signed [SAMPLE_W-1:0]              sample_q;
	logic signed [2:0]                       level_q;
	logic signed [2:0]                       level_d;
	logic                                    invert_q;
	logic [PATTERN_COUNT-1:0][PATTERN_W-1:0] pat_q;
	logic                                    sync_seen_q;
	logic                                    sync_seen_d;
	logic [2:0]                              sync_type;
	logic [21:0]                             pct_s1;
	logic [14:0]                             mag;
	logic [15:0]                             neg_min;
	logic signed [16:0]                      s2;
	logic signed [16:0]                      mx17;
	logic signed [16:0]                      mn17;
	logic signed [16:0]                      mid17;
	logic [6:0]                              pct_q0;
	logic [21:0]                             pct_rem;
	logic [6:0]                              ilvl;
	logic [OUT_TDATA_W-1:0]                  tdata_q;
	logic                                    tvalid_q;

	assign accept = s_tvalid && s_tready;

	fsk4_hist #(
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (hist_ctrl),
		.sample(sample_q),
		.stat  (hist_stat)
	);

	fsk4_sync u_sync (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (sync_ctrl),
		.level    (level_d),
		.patterns (pat_q),
		.sync_type(sync_type)
	);

	// Slice twice the sample against min, max and their sum
	always_comb begin
		s2    = {sample_q, 1'b0};
		mx17  = {2'b00, hist_stat.max};
		mn17  = {hist_stat.min[SAMPLE_W-1], hist_stat.min};
		mid17 = mx17 + mn17;
		if (s2 < mn17) begin
			level_d = LVL_N3;
		end else if (s2 > mn17 && s2 < mid17) begin
			level_d = LVL_N1;
		end else if (s2 > mid17 && s2 < mx17) begin
			level_d = LVL_P1;
		end else if (s2 > mx17) begin
			level_d = LVL_P3;
		end else begin
			level_d = LVL_ZERO;
		end
		if (invert_q) begin
			level_d = -level_d;
		end
	end

	// Larger magnitude of the extrema
	always_comb begin
		neg_min = 16'(-hist_stat.min);
		mag     = (neg_min[14:0] > hist_stat.max) ? neg_min[14:0] : hist_stat.max;
	end

	// Divide the scaled magnitude by the clip limit: shift estimate plus one correction
	always_comb begin
		pct_q0  = pct_s1[21:15];
		pct_rem = pct_s1 - 22'(pct_q0) * 22'(CLIP_MAG);
		ilvl    = (pct_rem >= 22'(CLIP_MAG)) ? pct_q0 + 7'd1 : pct_q0;
	end

	assign sync_seen_d = sync_seen_q || (sync_type != SYNC_NONE);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control
	always_comb begin
		state_d         = state_q;
		s_tready        = 1'b0;
		load_out        = 1'b0;
		hist_ctrl.start = 1'b0;
		hist_ctrl.clear = 1'b0;
		hist_ctrl.store = 1'b0;
		sync_ctrl.shift = 1'b0;
		sync_ctrl.clear = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser) begin
						hist_ctrl.clear = 1'b1;
						sync_ctrl.clear = 1'b1;
						state_d         = ST_DONE;
					end else begin
						hist_ctrl.start = 1'b1;
						state_d         = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (hist_stat.done) begin
					hist_ctrl.store = 1'b1;
					sync_ctrl.shift = 1'b1;
					state_d         = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Capture the input beat and the sliced level
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= s_tuser;
			sample_q <= $signed(s_tdata);
		end
		if (hist_ctrl.store) begin
			level_q <= level_d;
			pct_s1  <= 22'(mag) * 22'(PCT_SCALE);
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b0;
			pat_q[0] <= LSF_RESET;
			pat_q[1] <= STREAM_RESET;
			pat_q[2] <= PACKET_RESET;
			pat_q[3] <= BERT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INVERT: invert_q <= cfg_wdata[0];
				REG_LSF:    pat_q[0] <= cfg_wdata;
				REG_STREAM: pat_q[1] <= cfg_wdata;
				REG_PACKET: pat_q[2] <= cfg_wdata;
				REG_BERT:   pat_q[3] <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	// Sync flag: drop on carrier lost, set on any match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_seen_q <= 1'b0;
		end else if (hist_ctrl.clear) begin
			sync_seen_q <= 1'b0;
		end else if (load_out && !op_q) begin
			sync_seen_q <= sync_seen_d;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (load_out) begin
			tvalid_q <= 1'b1;
		end else if (m_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	// Output payload; carrier lost answers with all zero
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (op_q) begin
				tdata_q <= '0;
			end else begin
				tdata_q <= {1'b0, ilvl, hist_stat.min, hist_stat.max, sync_seen_d,
					sync_type, level_to_dibit(level_q), level_q};
			end
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;

endmodule

>>> rtl/fsk4_chk.sv
// Port-level checker of the slicer and sync detector, bound to the top level.
module fsk4_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [fsk4_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import fsk4_pkg::*;

	logic [2:0]  lvl;
	logic [1:0]  dib;
	logic [2:0]  styp;
	logic        insync;
	logic [14:0] wmax;
	logic [15:0] wmin;
	logic [6:0]  ilvl;
	logic        pad;

	assign lvl    = m_tdata[2:0];
	assign dib    = m_tdata[4:3];
	assign styp   = m_tdata[7:5];
	assign insync = m_tdata[8];
	assign wmax   = m_tdata[23:9];
	assign wmin   = m_tdata[39:24];
	assign ilvl   = m_tdata[46:40];
	assign pad    = m_tdata[47];

	// Hold a stalled result beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// Level is legal and the dibit follows from it
	a_dibit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (lvl == LVL_ZERO && dib == DIBIT_P1) || (lvl == LVL_P1 && dib == DIBIT_P1)
			|| (lvl == LVL_P3 && dib == DIBIT_P3) || (lvl == LVL_N1 && dib == DIBIT_N1)
			|| (lvl == LVL_N3 && dib == DIBIT_N3))
		else $error("symbol level and dibit disagree");

	// A found sync word raises the sync flag
	a_sync: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && styp != SYNC_NONE |-> insync)
		else $error("sync found without in_sync");

	// Extrema stay within the clip limit, the percent within scale, the pad bit low
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> wmax <= CLIP_MAG && $signed(wmin) >= -CLIP_LIMIT
			&& ilvl <= PCT_SCALE && !pad)
		else $error("extrema or input level out of range");

endmodule

bind fsk4_slicer_sync_detector_unit fsk4_chk u_fsk4_chk (.*);
